@@ rtl/lz77t10_pkg.sv @@
// Shared types and constants for the LZ77 type 0x10 stream decompressor.
// No dependencies; used by the top level and the testbench.
`default_nettype none

package lz77t10_pkg;

   // History depth default, field widths, token biases and configuration register defaults
   localparam int HISTORY_DEPTH_DEF = 4096;
   localparam int CSR_ADDR_W        = 3;
   localparam int CSR_DATA_W        = 32;
   localparam int LEN_W             = 24;
   localparam int DIST_W            = 13;
   localparam int COUNT_W           = 5;

   localparam logic [LEN_W-1:0]   MAX_LENGTH_RESET = 24'd85000;
   localparam logic [COUNT_W-1:0] TOKEN_LEN_BIAS   = 5'd3;
   localparam logic [DIST_W-1:0]  TOKEN_DIST_BIAS  = 13'd1;
   localparam logic [3:0]         FLAG_GROUP_SIZE  = 4'd8;

   // Register index, taken from paddr[2]
   localparam logic [0:0] REG_MAX_LENGTH = 1'b0;

   // Header byte slots
   localparam logic [1:0] HDR_TYPE  = 2'd0;
   localparam logic [1:0] HDR_LEN0  = 2'd1;
   localparam logic [1:0] HDR_LEN1  = 2'd2;
   localparam logic [1:0] HDR_LEN2  = 2'd3;

   // Stream parsing phase
   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_FLAG   = 2'd1,
      PH_DATA   = 2'd2,
      PH_TOKEN2 = 2'd3
   } phase_type;

   // Sequencer state
   typedef enum logic [1:0] {
      ST_IN   = 2'd0,
      ST_READ = 2'd1,
      ST_DATA = 2'd2
   } state_type;

endpackage

`default_nettype wire

@@ rtl/lz77t10_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module lz77t10_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/lz77_type10_decompressor.sv @@
// LZ77 type 0x10 decompressor. Header, flag, literal and token-high bytes each go in once
// the output register is free. A token's second byte starts a copy of 3..18 bytes, cut short
// at stream end, with input stalled: each byte is a history read then a write. Synchronous
// active-high reset clears control; no clearing pass runs, history entries not yet written
// since reset read as zero through the write pointer and wrap flag.
// Depends on lz77t10_pkg and lz77t10_ram.
`default_nettype none

module lz77_type10_decompressor #(
   parameter int HISTORY_DEPTH = lz77t10_pkg::HISTORY_DEPTH_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // input channel
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [7:0]                         req_in_byte,
   // result channel
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [7:0]                              rsp_out_byte,
   output logic                                    rsp_last,
   output logic                                    rsp_too_long,
   // configuration port
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [lz77t10_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [lz77t10_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [lz77t10_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                    csr_pready
);

   import lz77t10_pkg::*;

   localparam int AW = $clog2(HISTORY_DEPTH);
   localparam logic [AW:0]   DEPTH_W = (AW+1)'(HISTORY_DEPTH);
   localparam logic [AW-1:0] WP_LAST = AW'(HISTORY_DEPTH - 1);

   // Control and data registers
   state_type          state_ff, state_in;
   phase_type          phase_ff, phase_in;
   logic [1:0]         hidx_ff, hidx_in;
   logic [LEN_W-1:0]   rem_ff, rem_in;
   logic [7:0]         flag_bits_ff, flag_bits_in;
   logic [3:0]         flag_cnt_ff, flag_cnt_in;
   logic [7:0]         token_high_ff, token_high_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic [DIST_W-1:0]  dist_ff, dist_in;
   logic [AW-1:0]      wp_ff, wp_in;
   logic               full_ff, full_in;
   logic               src_ok_ff, src_ok_in;
   logic [LEN_W-1:0]   max_len_ff;

   // Output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         rsp_byte_ff, rsp_byte_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_tl_ff, rsp_tl_in;

   // History memory port signals
   logic               wr_en;
   logic [7:0]         wr_data;
   logic               rd_en;
   logic [AW-1:0]      src_idx;
   logic [7:0]         rd_data;

   logic               out_free;
   logic               accept;
   logic               elem_done;
   logic               cfg_wr;
   logic [LEN_W-1:0]   rem_dec;
   logic [LEN_W-1:0]   hdr_len;
   logic [AW:0]        wp_ext;
   logic [AW:0]        dist_ext;
   logic [AW:0]        diff;
   logic [AW-1:0]      wp_next;
   logic               wp_wrap;

   // Handshakes
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IN) && out_free);
   assign accept    = req_valid && !req_stall;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_last     = rsp_last_ff;
   assign rsp_too_long = rsp_tl_ff;

   // Configuration register
   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite
                       && (csr_paddr[2:2] == REG_MAX_LENGTH);
   assign csr_prdata = (csr_paddr[2:2] == REG_MAX_LENGTH)
                       ? CSR_DATA_W'(max_len_ff) : '0;

   // Shared address/count arithmetic
   assign rem_dec  = rem_ff - LEN_W'(1);
   assign hdr_len  = {req_in_byte, rem_ff[15:0]};
   assign wp_ext   = {1'b0, wp_ff};
   assign dist_ext = (AW+1)'(dist_ff);
   assign diff     = wp_ext - dist_ext;
   assign src_idx  = (wp_ext >= dist_ext) ? diff[AW-1:0] : AW'(diff + DEPTH_W);
   assign wp_wrap  = (wp_ff == WP_LAST);
   assign wp_next  = wp_wrap ? '0 : wp_ff + AW'(1);

   // History memory
   lz77t10_ram #(
      .WIDTH (8),
      .DEPTH (HISTORY_DEPTH),
      .AW    (AW)
   ) u_history (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wp_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (src_idx),
      .rd_data (rd_data)
   );

   // Sequencer: next state and datapath control
   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      hidx_in       = hidx_ff;
      rem_in        = rem_ff;
      flag_bits_in  = flag_bits_ff;
      flag_cnt_in   = flag_cnt_ff;
      token_high_in = token_high_ff;
      cnt_in        = cnt_ff;
      dist_in       = dist_ff;
      wp_in         = wp_ff;
      full_in       = full_ff;
      src_ok_in     = src_ok_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_byte_in   = rsp_byte_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_tl_in     = rsp_tl_ff;
      wr_en         = 1'b0;
      wr_data       = req_in_byte;
      rd_en         = 1'b0;
      elem_done     = 1'b0;

      unique case (state_ff)
         ST_IN: begin
            if (accept) begin
               unique case (phase_ff)
                  PH_HEADER: begin
                     case (hidx_ff)
                        HDR_TYPE: begin
                           rem_in  = '0;
                           hidx_in = HDR_LEN0;
                        end
                        HDR_LEN0: begin
                           rem_in[7:0] = req_in_byte;
                           hidx_in     = HDR_LEN1;
                        end
                        HDR_LEN1: begin
                           rem_in[15:8] = req_in_byte;
                           hidx_in      = HDR_LEN2;
                        end
                        default: begin
                           hidx_in = HDR_TYPE;
                           if (hdr_len > max_len_ff) begin
                              // oversize header: single error transfer
                              rem_in       = '0;
                              rsp_valid_in = 1'b1;
                              rsp_byte_in  = 8'd0;
                              rsp_last_in  = 1'b1;
                              rsp_tl_in    = 1'b1;
                           end else begin
                              rem_in = hdr_len;
                              if (hdr_len != '0) begin
                                 phase_in = PH_FLAG;
                              end
                           end
                        end
                     endcase
                  end
                  PH_FLAG: begin
                     flag_bits_in = req_in_byte;
                     flag_cnt_in  = FLAG_GROUP_SIZE;
                     phase_in     = PH_DATA;
                  end
                  PH_DATA: begin
                     if (flag_bits_ff[7]) begin
                        token_high_in = req_in_byte;
                        phase_in      = PH_TOKEN2;
                     end else begin
                        // literal byte
                        wr_en        = 1'b1;
                        wr_data      = req_in_byte;
                        wp_in        = wp_next;
                        full_in      = full_ff || wp_wrap;
                        rem_in       = rem_dec;
                        rsp_valid_in = 1'b1;
                        rsp_byte_in  = req_in_byte;
                        rsp_last_in  = (rem_dec == '0);
                        rsp_tl_in    = 1'b0;
                        elem_done    = 1'b1;
                     end
                  end
                  PH_TOKEN2: begin
                     cnt_in   = COUNT_W'({1'b0, token_high_ff[7:4]}) + TOKEN_LEN_BIAS;
                     dist_in  = DIST_W'({token_high_ff[3:0], req_in_byte}) + TOKEN_DIST_BIAS;
                     state_in = ST_READ;
                  end
                  default: begin
                     phase_in = PH_HEADER;
                  end
               endcase
            end
         end
         ST_READ: begin
            // entries never written since reset read as zero
            rd_en     = 1'b1;
            src_ok_in = full_ff || (src_idx < wp_ff);
            state_in  = ST_DATA;
         end
         ST_DATA: begin
            if (out_free) begin
               wr_en        = 1'b1;
               wr_data      = src_ok_ff ? rd_data : 8'd0;
               wp_in        = wp_next;
               full_in      = full_ff || wp_wrap;
               rem_in       = rem_dec;
               cnt_in       = cnt_ff - COUNT_W'(1);
               rsp_valid_in = 1'b1;
               rsp_byte_in  = src_ok_ff ? rd_data : 8'd0;
               rsp_last_in  = (rem_dec == '0);
               rsp_tl_in    = 1'b0;
               if ((rem_dec == '0) || (cnt_ff == COUNT_W'(1))) begin
                  elem_done = 1'b1;
                  state_in  = ST_IN;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IN;
         end
      endcase

      // end of one flag-group element
      if (elem_done) begin
         flag_bits_in = {flag_bits_ff[6:0], 1'b0};
         flag_cnt_in  = (flag_cnt_ff != 4'd0) ? flag_cnt_ff - 4'd1 : 4'd0;
         if (rem_in == '0) begin
            phase_in = PH_HEADER;
            hidx_in  = HDR_TYPE;
         end else if (flag_cnt_ff <= 4'd1) begin
            phase_in = PH_FLAG;
         end else begin
            phase_in = PH_DATA;
         end
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IN;
         phase_ff      <= PH_HEADER;
         hidx_ff       <= HDR_TYPE;
         rem_ff        <= '0;
         flag_bits_ff  <= '0;
         flag_cnt_ff   <= '0;
         token_high_ff <= '0;
         wp_ff         <= '0;
         full_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         max_len_ff    <= MAX_LENGTH_RESET;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         hidx_ff       <= hidx_in;
         rem_ff        <= rem_in;
         flag_bits_ff  <= flag_bits_in;
         flag_cnt_ff   <= flag_cnt_in;
         token_high_ff <= token_high_in;
         wp_ff         <= wp_in;
         full_ff       <= full_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (cfg_wr) begin
            max_len_ff <= csr_pwdata[LEN_W-1:0];
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      dist_ff     <= dist_in;
      src_ok_ff   <= src_ok_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
      rsp_tl_ff   <= rsp_tl_in;
   end

endmodule

`default_nettype wire

@@ rtl/lz77t10_checker.sv @@
// Port-level checker for the LZ77 type 0x10 decompressor, bound to the top level.
// Depends on lz77_type10_decompressor.
`default_nettype none

module lz77t10_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_last,
   input wire logic       rsp_too_long,
   input wire logic       csr_psel,
   input wire logic       csr_pready
);

   // error result is a zero byte that closes the stream
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_too_long |-> rsp_last && (rsp_out_byte == 8'd0))
      else $error("error result without last or with nonzero byte");

   // a held result stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte)
                                 && $stable(rsp_last) && $stable(rsp_too_long))
      else $error("stalled result changed");

   // no input transfer while a finished result is blocked
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("input taken while output blocked");

   // configuration port never waits
   assert property (@(posedge clock) disable iff (reset)
      csr_psel |-> csr_pready)
      else $error("pready low");

endmodule

bind lz77_type10_decompressor lz77t10_checker u_lz77t10_checker (.*);

`default_nettype wire

@@ tb/sv/lz77_type10_decompressor_tb.sv @@
// Self-checking testbench for the LZ77 type 0x10 stream decompressor.
// Depends on lz77t10_pkg and the lz77_type10_decompressor top level, and through it lz77t10_ram.
`timescale 1ns / 1ps

module lz77_type10_decompressor_tb;
   import lz77t10_pkg::*;

   localparam int HIST_AW      = $clog2(HISTORY_DEPTH_DEF);
   localparam int CYCLE_LIMIT  = 500000;
   localparam int SETTLE_CYCLES = 50;
   localparam int HOLD_CYCLES  = 400;
   localparam int PRINT_CAP    = 40;

   // CSR byte addresses
   localparam logic [CSR_ADDR_W-1:0] ADDR_MAX_LENGTH = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] ADDR_UNMAPPED   = 3'd4;

   // Receiver stall patterns
   localparam int STALL_NONE      = 0;
   localparam int STALL_RANDOM    = 1;
   localparam int STALL_ALTERNATE = 2;
   localparam int STALL_HEAVY     = 3;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
      logic       too_long;
   } result_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [7:0]            req_in_byte = 8'h00;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [7:0]            rsp_out_byte;
   logic                  rsp_last;
   logic                  rsp_too_long;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   lz77_type10_decompressor DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_in_byte  (req_in_byte),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last),
      .rsp_too_long (rsp_too_long),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Decoder shadow state
   logic [7:0]         hist_mem [0:HISTORY_DEPTH_DEF-1];
   logic [HIST_AW-1:0] wr_ptr;
   logic [LEN_W-1:0]   bytes_left;
   phase_type          parse_phase;
   logic [1:0]         hdr_slot;
   logic [7:0]         flag_reg;
   logic [3:0]         flags_left;
   logic [7:0]         tok_high;
   logic [LEN_W-1:0]   max_len_cfg;

   result_t decoded_queue [$];

   int  mismatch_count = 0;
   int  results_seen = 0;
   int  items_sent = 0;
   int  burst_left = 0;
   bit  gaps_enabled = 1'b1;
   bit  hold_request = 1'b0;
   bit  hold_served = 1'b0;
   int  hold_left = 0;
   int  stall_mode = STALL_NONE;
   int  pattern_left = 0;
   bit  stall_toggle = 1'b0;

   function automatic logic [7:0] rand_byte();
      logic [31:0] r;
      r = $urandom;
      return r[7:0];
   endfunction

   task automatic report_mismatch(input string what);
      if (mismatch_count < PRINT_CAP)
         $display("ERROR @%0t: %s", $time, what);
      mismatch_count++;
   endtask

   // ---------------------------------------------------------------
   // Decoder prediction
   // ---------------------------------------------------------------
   task automatic decoder_reset();
      for (int i = 0; i < HISTORY_DEPTH_DEF; i++)
         hist_mem[i] = 8'h00;
      wr_ptr      = '0;
      bytes_left  = '0;
      parse_phase = PH_HEADER;
      hdr_slot    = HDR_TYPE;
      flag_reg    = 8'h00;
      flags_left  = 4'd0;
      tok_high    = 8'h00;
      max_len_cfg = MAX_LENGTH_RESET;
   endtask

   // One decoded byte: into history and onto the expected queue
   task automatic push_decoded(input logic [7:0] value);
      result_t r;
      hist_mem[wr_ptr] = value;
      wr_ptr     = wr_ptr + 1'b1;
      bytes_left = bytes_left - 1'b1;
      r.out_byte = value;
      r.last     = (bytes_left == '0);
      r.too_long = 1'b0;
      decoded_queue.push_back(r);
   endtask

   // Advance to next flag bit, next group or next header
   task automatic finish_element();
      flag_reg   = flag_reg << 1;
      flags_left = (flags_left != 4'd0) ? flags_left - 1'b1 : 4'd0;
      if (bytes_left == '0) begin
         parse_phase = PH_HEADER;
         hdr_slot    = HDR_TYPE;
      end else if (flags_left == 4'd0) begin
         parse_phase = PH_FLAG;
      end else begin
         parse_phase = PH_DATA;
      end
   endtask

   task automatic decode_byte(input logic [7:0] b);
      result_t            r;
      logic [4:0]         copy_len;
      logic [DIST_W-1:0]  back_dist;
      logic [HIST_AW-1:0] rd_idx;
      case (parse_phase)
         PH_HEADER: begin
            case (hdr_slot)
               HDR_TYPE: begin
                  bytes_left = '0;
                  hdr_slot   = HDR_LEN0;
               end
               HDR_LEN0: begin
                  bytes_left[7:0] = b;
                  hdr_slot        = HDR_LEN1;
               end
               HDR_LEN1: begin
                  bytes_left[15:8] = b;
                  hdr_slot         = HDR_LEN2;
               end
               default: begin
                  bytes_left[23:16] = b;
                  hdr_slot          = HDR_TYPE;
                  if (bytes_left > max_len_cfg) begin
                     bytes_left = '0;
                     r.out_byte = 8'h00;
                     r.last     = 1'b1;
                     r.too_long = 1'b1;
                     decoded_queue.push_back(r);
                  end else if (bytes_left != '0) begin
                     parse_phase = PH_FLAG;
                  end
               end
            endcase
         end
         PH_FLAG: begin
            flag_reg    = b;
            flags_left  = FLAG_GROUP_SIZE;
            parse_phase = PH_DATA;
         end
         PH_DATA: begin
            if (flag_reg[7]) begin
               tok_high    = b;
               parse_phase = PH_TOKEN2;
            end else begin
               push_decoded(b);
               finish_element();
            end
         end
         default: begin
            // Back-reference copy; stops early when the stream is complete
            copy_len  = {1'b0, tok_high[7:4]} + TOKEN_LEN_BIAS;
            back_dist = {1'b0, tok_high[3:0], b} + TOKEN_DIST_BIAS;
            for (int i = 0; i < copy_len && bytes_left != '0; i++) begin
               rd_idx = wr_ptr - back_dist[HIST_AW-1:0];
               push_decoded(hist_mem[rd_idx]);
            end
            finish_element();
         end
      endcase
   endtask

   // ---------------------------------------------------------------
   // Input side
   // ---------------------------------------------------------------
   // Offer one byte, wait for the transfer, then predict. Valid stays high
   // into the next call unless a gap is drawn.
   task automatic send_byte(input logic [7:0] value);
      int gap;
      if (burst_left == 0) begin
         gap        = gaps_enabled ? $urandom_range(0, 6) : 0;
         burst_left = $urandom_range(1, 24);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_in_byte <= value;
      do @(posedge clock); while (!(req_valid && !req_stall));
      items_sent++;
      decode_byte(value);
   endtask

   task automatic send_header(input logic [7:0] kind, input int total);
      send_byte(kind);
      send_byte(total[7:0]);
      send_byte(total[15:8]);
      send_byte(total[23:16]);
   endtask

   // Well-formed stream with random literals and tokens
   task automatic send_stream(input int total, input int token_pct, input int dist_span,
                              input int long_pct);
      int         left;
      int         copy_len;
      int         dist_code;
      int         len_code;
      logic [7:0] flags;
      logic [7:0] kind;
      kind = ($urandom_range(0, 3) == 0) ? rand_byte() : 8'h10;
      send_header(kind, total);
      if (total == 0 || total > max_len_cfg)
         return;
      left = total;
      while (left > 0) begin
         for (int k = 0; k < 8; k++)
            flags[k] = ($urandom_range(0, 99) < token_pct);
         send_byte(flags);
         for (int k = 7; k >= 0 && left > 0; k--) begin
            if (flags[k]) begin
               copy_len  = ($urandom_range(0, 99) < long_pct) ? 18 : $urandom_range(3, 18);
               len_code  = copy_len - 3;
               dist_code = $urandom_range(1, dist_span) - 1;
               send_byte({len_code[3:0], dist_code[11:8]});
               send_byte(dist_code[7:0]);
               left -= (copy_len < left) ? copy_len : left;
            end else begin
               send_byte(rand_byte());
               left--;
            end
         end
      end
   endtask

   // Feed random bytes until the decoder sits at a header boundary
   task automatic resync_stream();
      while (!(parse_phase == PH_HEADER && hdr_slot == HDR_TYPE))
         send_byte(rand_byte());
   endtask

   // Stop offering input and let every expected result drain out
   task automatic drain_block();
      req_valid <= 1'b0;
      while (decoded_queue.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------
   // CSR access
   // ---------------------------------------------------------------
   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (addr == ADDR_MAX_LENGTH)
         max_len_cfg = data[LEN_W-1:0];
      @(posedge clock);
   endtask

   task automatic csr_read_check(input logic [CSR_ADDR_W-1:0] addr,
                                 input logic [CSR_DATA_W-1:0] want);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= addr;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== want)
         report_mismatch($sformatf("csr read addr %0d got %h want %h", addr, csr_prdata, want));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_max_length(input logic [LEN_W-1:0] value);
      csr_write(ADDR_MAX_LENGTH, {rand_byte(), value});
      csr_read_check(ADDR_MAX_LENGTH, {8'h00, value});
   endtask

   // ---------------------------------------------------------------
   // Result side: check each transfer, then pick the next stall value
   // ---------------------------------------------------------------
   always @(posedge clock) begin : result_monitor
      result_t want;
      if (rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (decoded_queue.size() == 0) begin
            report_mismatch($sformatf("unexpected result %0d: byte %h last %b too_long %b",
                                      results_seen, rsp_out_byte, rsp_last, rsp_too_long));
         end else begin
            want = decoded_queue.pop_front();
            if (rsp_out_byte !== want.out_byte)
               report_mismatch($sformatf("result %0d out_byte got %h want %h",
                                         results_seen, rsp_out_byte, want.out_byte));
            if (rsp_last !== want.last)
               report_mismatch($sformatf("result %0d last got %b want %b",
                                         results_seen, rsp_last, want.last));
            if (rsp_too_long !== want.too_long)
               report_mismatch($sformatf("result %0d too_long got %b want %b",
                                         results_seen, rsp_too_long, want.too_long));
         end
         results_seen++;
      end

      // One long hold-off on request, counted here
      if (hold_request && !hold_served) begin
         hold_left   = HOLD_CYCLES;
         hold_served = 1'b1;
      end
      if (pattern_left == 0) begin
         stall_mode   = $urandom_range(STALL_NONE, STALL_HEAVY);
         pattern_left = $urandom_range(10, 80);
      end else begin
         pattern_left--;
      end
      stall_toggle = !stall_toggle;

      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         case (stall_mode)
            STALL_RANDOM:    rsp_stall <= ($urandom_range(0, 99) < 40);
            STALL_ALTERNATE: rsp_stall <= stall_toggle;
            STALL_HEAVY:     rsp_stall <= ($urandom_range(0, 3) != 0);
            default:         rsp_stall <= 1'b0;
         endcase
      end
   end

   // Watchdog
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("lz77_type10_decompressor: mismatch");
      $finish;
   end

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------
   task automatic test_register_access();
      csr_read_check(ADDR_MAX_LENGTH, {8'h00, MAX_LENGTH_RESET});
      csr_write(ADDR_UNMAPPED, $urandom);
      csr_read_check(ADDR_MAX_LENGTH, {8'h00, MAX_LENGTH_RESET});
      set_max_length(MAX_LENGTH_RESET);
   endtask

   task automatic test_directed_streams();
      // Token reaching before any written data, then literal extremes
      send_header(8'h10, 5);
      send_byte(8'h80);
      send_byte(8'h0F);
      send_byte(8'hFF);
      send_byte(8'hFF);
      send_byte(8'h00);
      // Longest token running past the end of the stream, group left unfinished
      send_header(8'h00, 4);
      send_byte(8'h80);
      send_byte(8'hF0);
      send_byte(8'h01);
      // Length over the limit, then a zero-length header
      send_header(8'h10, 24'hFFFFFF);
      send_header(8'h10, 0);
      drain_block();
   endtask

   task automatic test_length_limit();
      set_max_length(24'd0);
      send_header(8'h10, 1);
      send_header(8'h10, 0);
      drain_block();
      set_max_length(24'd7);
      send_header(8'h10, 8);
      send_stream(7, 50, 16, 0);
      drain_block();
      set_max_length(24'hFFFFFF);
      send_stream(20, 50, 64, 20);
      drain_block();
   endtask

   task automatic test_random_streams();
      int round_end;
      int total;
      int pick;
      for (int round = 0; round < 4; round++) begin
         case (round)
            0:       set_max_length(24'hFFFFFF);
            1:       set_max_length(MAX_LENGTH_RESET);
            2:       set_max_length(24'd150);
            default: set_max_length($urandom_range(1, 600));
         endcase
         round_end = items_sent + 10;
         while (items_sent < round_end) begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
               total = 0;
            else if (pick < 75)
               total = $urandom_range(1, 24);
            else if (pick < 90)
               total = $urandom_range(25, 60);
            else if (max_len_cfg < 24'hFFFFFF)
               total = max_len_cfg + 1 + $urandom_range(0, 5000);
            else
               total = $urandom_range(1, 24);
            if (total > 24'hFFFFFF)
               total = 24'hFFFFFF;
            send_stream(total, $urandom_range(10, 90), $urandom_range(1, 4096), 30);
         end
         drain_block();
      end
   endtask

   // Token-heavy stream offered without gaps while the receiver holds off
   task automatic test_history_wrap_backpressure();
      set_max_length(24'hFFFFFF);
      gaps_enabled = 1'b0;
      hold_request = 1'b1;
      send_stream(400, 90, 4096, 70);
      gaps_enabled = 1'b1;
      drain_block();
   endtask

   // Raw noise and truncated streams, each followed by a resync
   task automatic test_noise_resync();
      set_max_length($urandom_range(0, 40));
      for (int i = 0; i < 16; i++)
         send_byte(rand_byte());
      resync_stream();
      for (int n = 0; n < 2; n++) begin
         send_header(rand_byte(), $urandom_range(0, max_len_cfg));
         for (int i = $urandom_range(1, 4); i > 0; i--)
            send_byte(rand_byte());
         send_header(8'h10, $urandom_range(1, 40));
         resync_stream();
      end
      drain_block();
   endtask

   initial begin
      decoder_reset();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_register_access();
      test_directed_streams();
      test_length_limit();
      test_random_streams();
      test_history_wrap_backpressure();
      test_noise_resync();

      drain_block();
      if (mismatch_count == 0)
         $display("lz77_type10_decompressor: match");
      else
         $display("lz77_type10_decompressor: mismatch");
      $finish;
   end

endmodule
